// File: src/cbz_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and command codes of the cubic Bezier timing solver.
// Depends on nothing; every other file of the block uses it.
package cbz_pkg;

	localparam int FRAC_BITS      = 16;
	localparam int MAX_ITERATIONS = 20;

	// fixed field widths
	localparam int TIME_W     = 17;
	localparam int CTRL_X_W   = 17;
	localparam int CTRL_Y_W   = 19;
	localparam int TOL_W      = 13;
	localparam int PROG_W     = 19;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;

	// internal datapath widths
	localparam int UW   = FRAC_BITS + 1;                        // unsigned value up to ONE
	localparam int MA_W = UW + 1;                               // multiplier operand a
	localparam int MB_W = ((UW > CTRL_Y_W) ? UW : CTRL_Y_W) + 1; // multiplier operand b
	localparam int PRW  = MA_W + MB_W;                          // product
	localparam int AW   = PRW + 2;                              // accumulator
	localparam int EW   = AW - FRAC_BITS;                       // curve value

	// register indexes
	typedef logic [CFG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_CTRL1_X   = 3'd0;
	localparam reg_idx_t REG_CTRL1_Y   = 3'd1;
	localparam reg_idx_t REG_CTRL2_X   = 3'd2;
	localparam reg_idx_t REG_CTRL2_Y   = 3'd3;
	localparam reg_idx_t REG_TOLERANCE = 3'd4;

	localparam logic [CTRL_X_W-1:0] CTRL1_X_RST   = 17'd16384;
	localparam logic [CTRL_Y_W-1:0] CTRL1_Y_RST   = 19'd16384;
	localparam logic [CTRL_X_W-1:0] CTRL2_X_RST   = 17'd49152;
	localparam logic [CTRL_Y_W-1:0] CTRL2_Y_RST   = 19'd49152;
	localparam logic [TOL_W-1:0]    TOLERANCE_RST = 13'd66;

	// multiplier operand selection
	typedef logic [2:0] mul_op_t;
	localparam mul_op_t MUL_NONE = 3'd0;
	localparam mul_op_t MUL_UU   = 3'd1;  // u * u
	localparam mul_op_t MUL_SS   = 3'd2;  // s * s
	localparam mul_op_t MUL_B1   = 3'd3;  // uu * s
	localparam mul_op_t MUL_B2   = 3'd4;  // ss * u
	localparam mul_op_t MUL_B3   = 3'd5;  // ss * s
	localparam mul_op_t MUL_P1   = 3'd6;  // b1 * p1
	localparam mul_op_t MUL_P2   = 3'd7;  // b2 * p2

	// product writeback
	typedef logic [2:0] wb_op_t;
	localparam wb_op_t WB_NONE = 3'd0;
	localparam wb_op_t WB_UU   = 3'd1;
	localparam wb_op_t WB_SS   = 3'd2;
	localparam wb_op_t WB_B1   = 3'd3;  // rounded triple product
	localparam wb_op_t WB_B2   = 3'd4;  // rounded triple product
	localparam wb_op_t WB_B3   = 3'd5;
	localparam wb_op_t WB_ACC1 = 3'd6;  // acc = product + b3 * ONE
	localparam wb_op_t WB_ACC2 = 3'd7;  // acc += product

	typedef struct packed {
		logic [CTRL_X_W-1:0]        ctrl1_x;
		logic signed [CTRL_Y_W-1:0] ctrl1_y;
		logic [CTRL_X_W-1:0]        ctrl2_x;
		logic signed [CTRL_Y_W-1:0] ctrl2_y;
		logic [TOL_W-1:0]           tolerance;
	} cbz_cfg_t;

	typedef struct packed {
		logic    load;    // latch time, reset the bracket
		logic    mid;     // take the bracket midpoint
		mul_op_t mul_op;
		wb_op_t  wb_op;
		logic    sel_y;   // multiply by the y control points
		logic    decide;  // compare x with time, narrow the bracket
		logic    fin;     // load the result register
	} cbz_cmd_t;

	typedef struct packed {
		logic match;
	} cbz_status_t;

endpackage

// File: src/cbz_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the solver: time sample, result, config write.
// Depends on cbz_pkg for the field widths.
interface cbz_sample_if;
	logic                        valid;
	logic                        ready;
	logic [cbz_pkg::TIME_W-1:0]  time_in;

	modport source (output valid, output time_in, input ready);
	modport sink (input valid, input time_in, output ready);
endinterface

interface cbz_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [cbz_pkg::PROG_W-1:0]  progress;
	logic                               converged;

	modport source (output valid, output progress, output converged, input ready);
	modport sink (input valid, input progress, input converged, output ready);
endinterface

interface cbz_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [cbz_pkg::CFG_IDX_W-1:0]    index;
	logic [cbz_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/cbz_regs.sv
`timescale 1ns / 1ps
// Configuration register file: control points and tolerance.
// Depends on cbz_pkg for widths, indexes and reset values.
module cbz_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [cbz_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [cbz_pkg::CFG_DATA_W-1:0]     wr_data,
	output cbz_pkg::cbz_cfg_t                  cfg
);

	cbz_pkg::cbz_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ctrl1_x   <= cbz_pkg::CTRL1_X_RST;
			cfg_q.ctrl1_y   <= cbz_pkg::CTRL1_Y_RST;
			cfg_q.ctrl2_x   <= cbz_pkg::CTRL2_X_RST;
			cfg_q.ctrl2_y   <= cbz_pkg::CTRL2_Y_RST;
			cfg_q.tolerance <= cbz_pkg::TOLERANCE_RST;
		end else if (wr_en) begin
			case (wr_index)
				cbz_pkg::REG_CTRL1_X:   cfg_q.ctrl1_x   <= wr_data[cbz_pkg::CTRL_X_W-1:0];
				cbz_pkg::REG_CTRL1_Y:   cfg_q.ctrl1_y   <= wr_data[cbz_pkg::CTRL_Y_W-1:0];
				cbz_pkg::REG_CTRL2_X:   cfg_q.ctrl2_x   <= wr_data[cbz_pkg::CTRL_X_W-1:0];
				cbz_pkg::REG_CTRL2_Y:   cfg_q.ctrl2_y   <= wr_data[cbz_pkg::CTRL_Y_W-1:0];
				cbz_pkg::REG_TOLERANCE: cfg_q.tolerance <= wr_data[cbz_pkg::TOL_W-1:0];
				default: ;  // drop writes to unknown indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/cbz_dp.sv
`timescale 1ns / 1ps
// Datapath: bisection bracket, shared multiplier, cubic accumulator, snap and clamp.
// Depends on cbz_pkg; driven cycle by cycle by the commands of cbz_ctrl.
module cbz_dp (
	input  logic                               clk,
	input  cbz_pkg::cbz_cmd_t                  cmd,
	input  cbz_pkg::cbz_cfg_t                  cfg,
	input  logic [cbz_pkg::TIME_W-1:0]         time_in,
	output cbz_pkg::cbz_status_t               status,
	output logic signed [cbz_pkg::PROG_W-1:0]  progress,
	output logic                               converged
);

	localparam int F    = cbz_pkg::FRAC_BITS;
	localparam int UW   = cbz_pkg::UW;
	localparam int MA_W = cbz_pkg::MA_W;
	localparam int MB_W = cbz_pkg::MB_W;
	localparam int PRW  = cbz_pkg::PRW;
	localparam int AW   = cbz_pkg::AW;
	localparam int EW   = cbz_pkg::EW;

	localparam logic [UW-1:0]         ONE_U  = {1'b1, {F{1'b0}}};
	localparam logic [PRW+1:0]        HALF_P = {{(PRW+2-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
	localparam logic signed [AW-1:0]  HALF_A = {{(AW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
	localparam logic signed [EW:0]    ONE_E  = {{(EW-F){1'b0}}, 1'b1, {F{1'b0}}};
	localparam logic signed [EW:0]    POS3_E = ONE_E + (ONE_E <<< 1);
	localparam logic signed [EW:0]    NEG2_E = -(ONE_E <<< 1);

	function automatic logic [UW-1:0] rnd(input logic [PRW+1:0] v);
		logic [PRW+1:0] r;
		r = v + HALF_P;
		return r[F+UW-1:F];
	endfunction

	function automatic logic signed [EW:0] absv(input logic signed [EW:0] v);
		return v[EW] ? -v : v;
	endfunction

	logic [cbz_pkg::TIME_W-1:0] time_q;
	logic [UW-1:0]              start_q, end_q, s_q, u_q;
	logic [UW-1:0]              uu_q, ss_q, b1_q, b2_q, b3_q;
	logic signed [PRW-1:0]      prod_q;
	logic signed [AW-1:0]       acc_q;
	logic                       match_q;
	logic signed [cbz_pkg::PROG_W-1:0] progress_q;
	logic                       converged_q;

	// operand selection for the shared multiplier
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [MB_W-1:0] p1, p2;
	logic signed [PRW-1:0]  prod_d;

	always_comb begin
		if (cmd.sel_y) begin
			p1 = $signed({{(MB_W-cbz_pkg::CTRL_Y_W){cfg.ctrl1_y[cbz_pkg::CTRL_Y_W-1]}},
				cfg.ctrl1_y});
			p2 = $signed({{(MB_W-cbz_pkg::CTRL_Y_W){cfg.ctrl2_y[cbz_pkg::CTRL_Y_W-1]}},
				cfg.ctrl2_y});
		end else begin
			p1 = $signed({{(MB_W-cbz_pkg::CTRL_X_W){1'b0}}, cfg.ctrl1_x});
			p2 = $signed({{(MB_W-cbz_pkg::CTRL_X_W){1'b0}}, cfg.ctrl2_x});
		end
	end

	always_comb begin
		case (cmd.mul_op)
			cbz_pkg::MUL_UU: begin
				mul_a = $signed({1'b0, u_q});
				mul_b = $signed({{(MB_W-UW){1'b0}}, u_q});
			end
			cbz_pkg::MUL_SS: begin
				mul_a = $signed({1'b0, s_q});
				mul_b = $signed({{(MB_W-UW){1'b0}}, s_q});
			end
			cbz_pkg::MUL_B1: begin
				mul_a = $signed({1'b0, uu_q});
				mul_b = $signed({{(MB_W-UW){1'b0}}, s_q});
			end
			cbz_pkg::MUL_B2: begin
				mul_a = $signed({1'b0, ss_q});
				mul_b = $signed({{(MB_W-UW){1'b0}}, u_q});
			end
			cbz_pkg::MUL_B3: begin
				mul_a = $signed({1'b0, ss_q});
				mul_b = $signed({{(MB_W-UW){1'b0}}, s_q});
			end
			cbz_pkg::MUL_P1: begin
				mul_a = $signed({1'b0, b1_q});
				mul_b = p1;
			end
			cbz_pkg::MUL_P2: begin
				mul_a = $signed({1'b0, b2_q});
				mul_b = p2;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// product post-processing; the rounded terms are never negative
	logic [PRW+1:0]        prod_u, prod_tri;
	logic signed [AW-1:0]  prod_ext, b3_sh;

	assign prod_u   = {2'b00, prod_q};
	assign prod_tri = (prod_u << 1) + prod_u;
	assign prod_ext = {{2{prod_q[PRW-1]}}, prod_q};
	assign b3_sh    = $signed({{(AW-UW){1'b0}}, b3_q} << F);

	// curve value and time compare
	logic signed [AW-1:0] rsum;
	logic signed [EW:0]   est, t_ext, diff, tol_ext;
	logic signed [EW:0]   snapped, sat;
	logic                 match;

	assign rsum    = acc_q + HALF_A;
	assign est     = $signed({rsum[AW-1], rsum[AW-1:F]});
	assign t_ext   = $signed({{(EW+1-cbz_pkg::TIME_W){1'b0}}, time_q});
	assign tol_ext = $signed({{(EW+1-cbz_pkg::TOL_W){1'b0}}, cfg.tolerance});
	assign diff    = t_ext - est;
	assign match   = absv(diff) < tol_ext;

	always_comb begin
		if (absv(est) < tol_ext)
			snapped = '0;
		else if (absv(est - ONE_E) < tol_ext)
			snapped = ONE_E;
		else
			snapped = est;
		if (snapped < NEG2_E)
			sat = NEG2_E;
		else if (snapped > POS3_E)
			sat = POS3_E;
		else
			sat = snapped;
	end

	logic [UW:0]   mid_sum;
	logic [UW-1:0] mid;

	assign mid_sum = {1'b0, start_q} + {1'b0, end_q};
	assign mid     = mid_sum[UW:1];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			time_q  <= time_in;
			start_q <= '0;
			end_q   <= ONE_U;
		end
		if (cmd.mid) begin
			s_q <= mid;
			u_q <= ONE_U - mid;
		end
		prod_q <= prod_d;
		case (cmd.wb_op)
			cbz_pkg::WB_UU:   uu_q  <= rnd(prod_u);
			cbz_pkg::WB_SS:   ss_q  <= rnd(prod_u);
			cbz_pkg::WB_B1:   b1_q  <= rnd(prod_tri);
			cbz_pkg::WB_B2:   b2_q  <= rnd(prod_tri);
			cbz_pkg::WB_B3:   b3_q  <= rnd(prod_u);
			cbz_pkg::WB_ACC1: acc_q <= prod_ext + b3_sh;
			cbz_pkg::WB_ACC2: acc_q <= acc_q + prod_ext;
			default: ;
		endcase
		if (cmd.decide) begin
			match_q <= match;
			// x below time: move the lower bound up, else pull the upper bound down
			if (!match) begin
				if (diff > 0)
					start_q <= s_q;
				else
					end_q <= s_q;
			end
		end
		if (cmd.fin) begin
			progress_q  <= sat[cbz_pkg::PROG_W-1:0];
			converged_q <= match_q;
		end
	end

	assign status.match = match;
	assign progress     = progress_q;
	assign converged    = converged_q;

endmodule

// File: src/cbz_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences the bisection steps and the final y evaluation,
// owns the input ready and the result valid. Depends on cbz_pkg.
module cbz_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  cbz_pkg::cbz_status_t  status,
	output cbz_pkg::cbz_cmd_t     cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ITER  = 2'd1;
	localparam logic [1:0] ST_YEVAL = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam logic [3:0] STEP_MID    = 4'd0;
	localparam logic [3:0] STEP_UU     = 4'd1;
	localparam logic [3:0] STEP_SS     = 4'd2;
	localparam logic [3:0] STEP_B1     = 4'd3;
	localparam logic [3:0] STEP_B2     = 4'd4;
	localparam logic [3:0] STEP_B3     = 4'd5;
	localparam logic [3:0] STEP_P1     = 4'd6;
	localparam logic [3:0] STEP_P2     = 4'd7;
	localparam logic [3:0] STEP_ACC    = 4'd8;
	localparam logic [3:0] STEP_DECIDE = 4'd9;

	localparam logic [3:0] YSTEP_P1  = 4'd0;
	localparam logic [3:0] YSTEP_P2  = 4'd1;
	localparam logic [3:0] YSTEP_ACC = 4'd2;

	localparam int IW = $clog2(cbz_pkg::MAX_ITERATIONS);
	localparam logic [IW-1:0] LAST_ITER = IW'(cbz_pkg::MAX_ITERATIONS - 1);

	logic [1:0]    state_q;
	logic [3:0]    step_q;
	logic [IW-1:0] iter_q;
	logic          out_valid_q;
	logic          out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd        = '0;
		cmd.mul_op = cbz_pkg::MUL_NONE;
		cmd.wb_op  = cbz_pkg::WB_NONE;
		case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_ITER: begin
				case (step_q)
					STEP_MID: cmd.mid = 1'b1;
					STEP_UU:  cmd.mul_op = cbz_pkg::MUL_UU;
					STEP_SS: begin
						cmd.mul_op = cbz_pkg::MUL_SS;
						cmd.wb_op  = cbz_pkg::WB_UU;
					end
					STEP_B1: begin
						cmd.mul_op = cbz_pkg::MUL_B1;
						cmd.wb_op  = cbz_pkg::WB_SS;
					end
					STEP_B2: begin
						cmd.mul_op = cbz_pkg::MUL_B2;
						cmd.wb_op  = cbz_pkg::WB_B1;
					end
					STEP_B3: begin
						cmd.mul_op = cbz_pkg::MUL_B3;
						cmd.wb_op  = cbz_pkg::WB_B2;
					end
					STEP_P1: begin
						cmd.mul_op = cbz_pkg::MUL_P1;
						cmd.wb_op  = cbz_pkg::WB_B3;
					end
					STEP_P2: begin
						cmd.mul_op = cbz_pkg::MUL_P2;
						cmd.wb_op  = cbz_pkg::WB_ACC1;
					end
					STEP_ACC:    cmd.wb_op = cbz_pkg::WB_ACC2;
					STEP_DECIDE: cmd.decide = 1'b1;
					default: ;
				endcase
			end
			ST_YEVAL: begin
				cmd.sel_y = 1'b1;
				case (step_q)
					YSTEP_P1: cmd.mul_op = cbz_pkg::MUL_P1;
					YSTEP_P2: begin
						cmd.mul_op = cbz_pkg::MUL_P2;
						cmd.wb_op  = cbz_pkg::WB_ACC1;
					end
					YSTEP_ACC: cmd.wb_op = cbz_pkg::WB_ACC2;
					default: ;
				endcase
			end
			ST_FIN:  cmd.fin = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_ITER;
						step_q  <= STEP_MID;
						iter_q  <= '0;
					end
				end
				ST_ITER: begin
					if (step_q == STEP_DECIDE) begin
						step_q <= STEP_MID;
						// stop on a match or at the iteration cap
						if (status.match || iter_q == LAST_ITER)
							state_q <= ST_YEVAL;
						else
							iter_q <= iter_q + 1'b1;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_YEVAL: begin
					if (step_q == YSTEP_ACC)
						state_q <= ST_FIN;
					else
						step_q <= step_q + 1'b1;
				end
				ST_FIN: begin
					// hold the result until the output slot frees up
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_ITER && step_q == STEP_MID && iter_q == '0))
		else $error("bisection did not restart on a new item");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER) |-> (iter_q <= LAST_ITER))
		else $error("iteration count past the cap");

	a_keep_going: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER && step_q == STEP_DECIDE && !status.match && iter_q != LAST_ITER)
		|=> (state_q == ST_ITER && step_q == STEP_MID))
		else $error("bisection left early");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (!out_valid_q || out_ready))
		else $error("result register loaded while a result waits");

endmodule

// File: src/cubic_bezier_timing_solver.sv
`timescale 1ns / 1ps
// Top level of the cubic Bezier timing solver: config registers, controller, datapath.
// Depends on cbz_pkg, cbz_ifs, cbz_regs, cbz_ctrl and cbz_dp.
//
// Usage:
//   cfg    - register writes (index 0..4: ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
//            tolerance). Always ready; unknown indexes are dropped. Write only
//            while no item is in flight.
//   sample - one time value per item, taken while the solver is idle.
//   result - progress (curve y, snapped to 0 or 1.0, clamped to [-2, 3])
//            and converged (0 when the iteration cap was hit).
// Sequence: one bisection step runs through the shared multiplier (midpoint,
//   five basis products, two weighted products, accumulate, compare). After
//   n steps (1 to MAX_ITERATIONS) the y evaluation runs and the result is
//   loaded; the next item can be taken in the cycle after the result is loaded,
//   so the solver works on one item at a time.
// Reset: registers return to their defaults, no result is pending.
// Stall: a result waits in the output register; the solver takes the next item
//   and runs it, then holds in its final step until the waiting result is taken.
module cubic_bezier_timing_solver (
	input  logic         clk,
	input  logic         arst_n,
	cbz_cfg_if.sink      cfg,
	cbz_sample_if.sink   sample,
	cbz_result_if.source result
);

	cbz_pkg::cbz_cfg_t    cfg_regs;
	cbz_pkg::cbz_cmd_t    cmd;
	cbz_pkg::cbz_status_t status;

	assign cfg.ready = 1'b1;

	cbz_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	cbz_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	cbz_dp u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.cfg       (cfg_regs),
		.time_in   (sample.time_in),
		.status    (status),
		.progress  (result.progress),
		.converged (result.converged)
	);

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for cubic_bezier_timing_solver: directed table, then random config phases and times.
// Depends on cbz_pkg, cbz_ifs and the solver RTL; predicts each result and checks it in order.
module tb_top;

	localparam longint ONE_Q  = longint'(1) << cbz_pkg::FRAC_BITS;
	localparam longint HALF_Q = longint'(1) << (cbz_pkg::FRAC_BITS - 1);
	localparam int     CYCLE_LIMIT = 2_000_000;
	localparam int     RAND_PHASES = 13;
	localparam int     PHASE_ITEMS = 100;

	// indexes the block decodes to nothing
	localparam cbz_pkg::reg_idx_t REG_SPARE_5 = 3'd5;
	localparam cbz_pkg::reg_idx_t REG_SPARE_6 = 3'd6;
	localparam cbz_pkg::reg_idx_t REG_SPARE_7 = 3'd7;

	typedef struct {
		logic signed [cbz_pkg::PROG_W-1:0] progress;
		logic                              converged;
	} bez_result_t;

	typedef enum logic {ROW_CFG, ROW_TIME} row_kind_t;

	// idx is unused on time rows; prog/conv only count where typed is set
	typedef struct packed {
		row_kind_t                         kind;
		cbz_pkg::reg_idx_t                 idx;
		logic [cbz_pkg::CFG_DATA_W-1:0]    val;
		logic                              typed;
		logic signed [cbz_pkg::PROG_W-1:0] prog;
		logic                              conv;
	} dir_row_t;

	localparam int DIR_ROWS = 39;
	dir_row_t dir_steps [DIR_ROWS] = '{
		'{ROW_CFG,  REG_SPARE_5,            19'h7FFFF, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  REG_SPARE_6,            19'h7FFFF, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  REG_SPARE_7,            19'h2AAAA, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h00000, 1'b1, 19'sd0,     1'b1},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h10000, 1'b1, 19'sd65536, 1'b1},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h08000, 1'b1, 19'sd32768, 1'b1},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h00001, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h0FFFF, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h1FFFF, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h18000, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_TOLERANCE, 19'h00000, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h08000, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h00000, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h10000, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_TOLERANCE, 19'h01FFF, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_CTRL1_Y,   19'h60000, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_CTRL2_Y,   19'h30000, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h04E20, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h0AFC8, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_CTRL1_X,   19'h00000, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_CTRL2_X,   19'h10000, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_TOLERANCE, 19'h00001, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h00064, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h0FDE8, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h08000, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_CTRL1_X,   19'h1FFFF, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_CTRL2_X,   19'h1FFFF, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_CTRL1_Y,   19'h3FFFF, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_CTRL2_Y,   19'h40000, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_TOLERANCE, 19'h00042, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h00000, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h0C350, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h1FFFF, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_CTRL1_X,   19'h10000, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_CTRL2_X,   19'h00000, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_CTRL1_Y,   19'h00000, 1'b0, 19'sd0,     1'b0},
		'{ROW_CFG,  cbz_pkg::REG_CTRL2_Y,   19'h10000, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h02710, 1'b0, 19'sd0,     1'b0},
		'{ROW_TIME, cbz_pkg::REG_CTRL1_X,   19'h0EA60, 1'b0, 19'sd0,     1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;

	cbz_cfg_if    cfg_bus ();
	cbz_sample_if smp ();
	cbz_result_if res ();

	cubic_bezier_timing_solver i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.sample (smp),
		.result (res)
	);

	always #4 clk = ~clk;

	// register copy, as the block should hold it
	logic [cbz_pkg::CTRL_X_W-1:0]        cfg_c1x = cbz_pkg::CTRL1_X_RST;
	logic signed [cbz_pkg::CTRL_Y_W-1:0] cfg_c1y = cbz_pkg::CTRL1_Y_RST;
	logic [cbz_pkg::CTRL_X_W-1:0]        cfg_c2x = cbz_pkg::CTRL2_X_RST;
	logic signed [cbz_pkg::CTRL_Y_W-1:0] cfg_c2y = cbz_pkg::CTRL2_Y_RST;
	logic [cbz_pkg::TOL_W-1:0]           cfg_tol = cbz_pkg::TOLERANCE_RST;

	bez_result_t progress_q[$];
	int          mismatch_cnt = 0;
	int          result_cnt = 0;
	int          cycle_cnt = 0;
	int          rcv_hold = 0;

	function automatic longint round_q(longint v);
		return (v + HALF_Q) >>> cbz_pkg::FRAC_BITS;
	endfunction

	// Bernstein form with both end points fixed; shift is a floor for negative sums too
	function automatic longint curve_at(longint s, longint p1, longint p2);
		longint u, uu, ss, b1, b2, b3, acc;
		u   = ONE_Q - s;
		uu  = round_q(u * u);
		ss  = round_q(s * s);
		b1  = round_q(3 * uu * s);
		b2  = round_q(3 * u * ss);
		b3  = round_q(ss * s);
		acc = b1 * p1 + b2 * p2 + b3 * ONE_Q;
		return (acc + HALF_Q) >>> cbz_pkg::FRAC_BITS;
	endfunction

	function automatic bez_result_t solve_progress(logic [cbz_pkg::TIME_W-1:0] t_in);
		bez_result_t r;
		longint t, tol, lo, hi, mid, est, y;
		bit hit;
		int i;
		t   = longint'(t_in);
		tol = longint'(cfg_tol);
		lo  = 0;
		hi  = ONE_Q;
		mid = 0;
		hit = 1'b0;
		for (i = 0; i < cbz_pkg::MAX_ITERATIONS && !hit; i++) begin
			mid = (lo + hi) >>> 1;
			est = curve_at(mid, longint'(cfg_c1x), longint'(cfg_c2x));
			if (((t > est) ? t - est : est - t) < tol) begin
				hit = 1'b1;
			end else if (est < t) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		y = curve_at(mid, longint'(cfg_c1y), longint'(cfg_c2y));
		if (((y > 0) ? y : -y) < tol) begin
			y = 0;
		end else if (((y > ONE_Q) ? y - ONE_Q : ONE_Q - y) < tol) begin
			y = ONE_Q;
		end
		if (y < -2 * ONE_Q) y = -2 * ONE_Q;
		if (y > 3 * ONE_Q) y = 3 * ONE_Q;
		r.progress  = y[cbz_pkg::PROG_W-1:0];
		r.converged = hit;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch on result %0d, %s: got %0d, expected %0d", result_cnt, what, got, want);
		mismatch_cnt++;
	endtask

	function automatic int pick_gap(bit no_gap);
		int r;
		r = $urandom_range(99);
		if (no_gap || r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [cbz_pkg::CFG_DATA_W-1:0] pick_ctrl_x();
		int r;
		r = $urandom_range(99);
		if (r < 10) return 19'd0;
		if (r < 20) return 19'd65536;
		if (r < 25) return 19'($urandom_range(131071));
		return 19'($urandom_range(65536));
	endfunction

	function automatic logic [cbz_pkg::CFG_DATA_W-1:0] pick_ctrl_y();
		int r;
		r = $urandom_range(99);
		if (r < 10) return 19'h60000;
		if (r < 20) return 19'h30000;
		if (r < 25) return 19'($urandom_range(524287));
		return 19'($urandom_range(327680) - 131072);
	endfunction

	// called at a falling edge; leaves valid high so the next item can follow at once
	task automatic send_time(logic [cbz_pkg::TIME_W-1:0] t, int gap, logic typed,
			logic signed [cbz_pkg::PROG_W-1:0] prog, logic conv);
		bez_result_t r;
		if (gap > 0) begin
			smp.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		smp.time_in = t;
		smp.valid   = 1'b1;
		do @(posedge clk); while (!smp.ready);
		if (typed) begin
			r.progress  = prog;
			r.converged = conv;
		end else begin
			r = solve_progress(t);
		end
		progress_q.push_back(r);
		@(negedge clk);
	endtask

	task automatic drain_results();
		smp.valid = 1'b0;
		while (progress_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(cbz_pkg::reg_idx_t idx, logic [cbz_pkg::CFG_DATA_W-1:0] val);
		drain_results();
		cfg_bus.index = idx;
		cfg_bus.data  = val;
		cfg_bus.valid = 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			cbz_pkg::REG_CTRL1_X:   cfg_c1x = val[cbz_pkg::CTRL_X_W-1:0];
			cbz_pkg::REG_CTRL1_Y:   cfg_c1y = val[cbz_pkg::CTRL_Y_W-1:0];
			cbz_pkg::REG_CTRL2_X:   cfg_c2x = val[cbz_pkg::CTRL_X_W-1:0];
			cbz_pkg::REG_CTRL2_Y:   cfg_c2y = val[cbz_pkg::CTRL_Y_W-1:0];
			cbz_pkg::REG_TOLERANCE: cfg_tol = val[cbz_pkg::TOL_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// result side: random short stalls, rare long ones, calm stretches, and the hold-off
	initial begin
		int gap_cnt, calm_cnt, r;
		gap_cnt   = 0;
		calm_cnt  = 0;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rcv_hold > 0) begin
				res.ready = 1'b0;
				rcv_hold--;
			end else if (gap_cnt > 0) begin
				res.ready = 1'b0;
				gap_cnt--;
			end else begin
				res.ready = 1'b1;
				if (calm_cnt > 0) begin
					calm_cnt--;
				end else begin
					r = $urandom_range(99);
					if (r < 2) calm_cnt = $urandom_range(100, 400);
					else if (r < 22) gap_cnt = $urandom_range(1, 3);
					else if (r < 25) gap_cnt = $urandom_range(20, 80);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (progress_q.size() == 0) begin
				report_mismatch("unexpected item, progress", longint'(res.progress), 0);
			end else begin
				bez_result_t e;
				e = progress_q.pop_front();
				if (res.progress !== e.progress)
					report_mismatch("progress", longint'(res.progress), longint'(e.progress));
				if (res.converged !== e.converged)
					report_mismatch("converged", longint'(res.converged), longint'(e.converged));
			end
			result_cnt++;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, progress_q.size());
			$display("FAIL cubic_bezier_timing_solver");
			$finish;
		end
	end

	initial begin
		int row, ph, k, r;
		bit no_gap;
		logic [cbz_pkg::TIME_W-1:0] t;
		arst_n        = 1'b0;
		smp.valid     = 1'b0;
		smp.time_in   = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data  = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (row = 0; row < DIR_ROWS; row++) begin
			if (dir_steps[row].kind == ROW_CFG) begin
				write_reg(dir_steps[row].idx, dir_steps[row].val);
			end else begin
				send_time(dir_steps[row].val[cbz_pkg::TIME_W-1:0], pick_gap(1'b0),
					dir_steps[row].typed, dir_steps[row].prog, dir_steps[row].conv);
			end
		end

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == RAND_PHASES - 1) begin
				write_reg(cbz_pkg::REG_CTRL1_X, 19'(cbz_pkg::CTRL1_X_RST));
				write_reg(cbz_pkg::REG_CTRL1_Y, 19'(cbz_pkg::CTRL1_Y_RST));
				write_reg(cbz_pkg::REG_CTRL2_X, 19'(cbz_pkg::CTRL2_X_RST));
				write_reg(cbz_pkg::REG_CTRL2_Y, 19'(cbz_pkg::CTRL2_Y_RST));
				write_reg(cbz_pkg::REG_TOLERANCE, 19'(cbz_pkg::TOLERANCE_RST));
			end else begin
				write_reg(cbz_pkg::REG_CTRL1_X, pick_ctrl_x());
				write_reg(cbz_pkg::REG_CTRL1_Y, pick_ctrl_y());
				write_reg(cbz_pkg::REG_CTRL2_X, pick_ctrl_x());
				write_reg(cbz_pkg::REG_CTRL2_Y, pick_ctrl_y());
				r = $urandom_range(99);
				if (r < 8) write_reg(cbz_pkg::REG_TOLERANCE, 19'd1);
				else if (r < 16) write_reg(cbz_pkg::REG_TOLERANCE, 19'd4096);
				else if (r < 20) write_reg(cbz_pkg::REG_TOLERANCE, 19'd0);
				else if (r < 25)
					write_reg(cbz_pkg::REG_TOLERANCE, 19'($urandom_range(8191)));
				else if (r < 60)
					write_reg(cbz_pkg::REG_TOLERANCE, 19'($urandom_range(1, 200)));
				else
					write_reg(cbz_pkg::REG_TOLERANCE, 19'($urandom_range(1, 4096)));
			end
			no_gap = (ph % 4 == 1);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				// hold the result side so the solver fills and stalls its input
				if (ph == 3 && k == 20) rcv_hold = 500;
				// pause until the block is empty
				if (ph == 5 && k == 50) drain_results();
				r = $urandom_range(99);
				if (r < 70) t = 17'($urandom_range(65536));
				else if (r < 80) t = 17'($urandom_range(3) == 0 ? 0 : 65536);
				else if (r < 85) t = 17'($urandom_range(1) ? 1 : 65535);
				else t = 17'($urandom_range(131071));
				send_time(t, pick_gap(no_gap), 1'b0, '0, 1'b0);
			end
		end

		drain_results();
		repeat (250) @(negedge clk);
		if (mismatch_cnt == 0) begin
			$display("PASS cubic_bezier_timing_solver");
		end else begin
			$display("FAIL cubic_bezier_timing_solver");
		end
		$finish;
	end

endmodule
